// ===== rtl/core/phh_pkg.sv =====
// shared types and constants for the pc profile histogram
package phh_pkg;

  localparam logic CFG_CODE_BASE = 1'b0;
  localparam logic CFG_TOP_N     = 1'b1;
  localparam logic KIND_STEP     = 1'b0;
  localparam logic KIND_DUMP     = 1'b1;
  localparam logic [6:0] MAX_REPORT = 7'd64;
  localparam logic [31:0] CODE_BASE_RST = 32'h0000_8000;
  localparam logic [6:0] TOP_N_RST = 7'd10;

  typedef struct packed {
    logic        kind;
    logic [31:0] pc;
    logic [31:0] cycles;
  } in_t;

  typedef struct packed {
    logic [31:0] inst_addr;
    logic [31:0] exec_count;
    logic [31:0] avg_cycles;
    logic [31:0] total_steps;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        kind;
    logic        in_range;
    logic [29:0] word;
    logic [31:0] cycles;
  } qitem_t;

endpackage

// ===== rtl/core/phh_front.sv =====
// front end: accepts items, computes the table index and queues them
module phh_front import phh_pkg::*; #(
  parameter int ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_start,
  input  in_t         in_data,
  input  logic [31:0] code_base,
  input  logic        clearing,
  output logic        busy,
  input  logic        q_pop,
  output logic        q_valid,
  output qitem_t      q_item
);

  qitem_t      mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic [31:0] diff;
  qitem_t      item;

  assign diff          = in_data.pc - code_base;
  assign item.kind     = in_data.kind;
  assign item.word     = diff[31:2];
  assign item.in_range = ({2'b00, diff[31:2]} < 32'(ENTRIES));
  assign item.cycles   = in_data.cycles;

  assign busy    = (cnt_r == 2'd2) | clearing;
  assign push    = in_start & ~busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== rtl/core/phh_back.sv =====
// back end: count and cycle tables, step updates and dump ranking
module phh_back import phh_pkg::*; #(
  parameter int ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] code_base,
  input  logic [6:0]  top_n,
  input  logic        q_valid,
  input  qitem_t      q_item,
  output logic        q_pop,
  output logic        clearing,
  output logic        out_valid,
  output out_t        out_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SRD, S_SWR, S_SCAN, S_CYC, S_LOAD, S_DIV
  } state_t;

  logic [31:0] count_mem [ENTRIES];
  logic [31:0] cyc_mem   [ENTRIES];

  state_t      state_r;
  qitem_t      cur_r;
  logic [IW-1:0] clr_r, prev_idx_r, scan_r, cmp_idx_r, best_idx_r, rank_idx_r;
  logic        prev_v_r, scan_done_r, cmp_v_r, found_r, have_prev_r, pend_v_r;
  logic [31:0] step_total_r, best_cnt_r, rank_cnt_r, rem_r, quo_r;
  logic [6:0]  n_r, limit_r;
  logic [4:0]  k_r;
  out_t        pend_r, out_r;
  logic        out_valid_r;
  logic [31:0] cnt_rd_r, cyc_rd_r;

  logic [IW-1:0] cnt_ra, cyc_ra, cnt_wa, cyc_wa;
  logic        cnt_we, cyc_we;
  logic [31:0] cnt_wd, cyc_wd;
  logic [IW-1:0] cur_idx;
  logic        cand_ok, cand_better;
  logic [32:0] sh, trial;
  logic [31:0] quo_nxt, rem_nxt;
  logic [6:0]  limit_nxt;

  assign cur_idx   = cur_r.word[IW-1:0];
  assign clearing  = (state_r == S_CLR);
  assign q_pop     = (state_r == S_IDLE) & q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign limit_nxt = (top_n == 7'd0) ? 7'd1 : (top_n > MAX_REPORT) ? MAX_REPORT : top_n;

  assign cand_ok = (cnt_rd_r != 32'd0) &&
                   (!have_prev_r || (rank_cnt_r > cnt_rd_r) ||
                    ((rank_cnt_r == cnt_rd_r) && (rank_idx_r < cmp_idx_r)));
  assign cand_better = !found_r || (cnt_rd_r > best_cnt_r);

  assign sh      = {rem_r, quo_r[31]};
  assign trial   = sh - {1'b0, best_cnt_r};
  assign rem_nxt = trial[32] ? sh[31:0] : trial[31:0];
  assign quo_nxt = {quo_r[30:0], ~trial[32]};

  always_comb begin
    cnt_ra = scan_r;
    cyc_ra = best_idx_r;
    cnt_we = 1'b0;
    cyc_we = 1'b0;
    cnt_wa = cur_idx;
    cyc_wa = prev_idx_r;
    cnt_wd = cnt_rd_r + 32'd1;
    cyc_wd = cyc_rd_r + cur_r.cycles;
    unique case (state_r)
      S_CLR: begin
        cnt_we = 1'b1;
        cyc_we = 1'b1;
        cnt_wa = clr_r;
        cyc_wa = clr_r;
        cnt_wd = 32'd0;
        cyc_wd = 32'd0;
      end
      S_SRD: begin
        cnt_ra = cur_idx;
        cyc_ra = prev_idx_r;
      end
      S_SWR: begin
        cnt_we = cur_r.in_range;
        cyc_we = prev_v_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) count_mem[cnt_wa] <= cnt_wd;
    cnt_rd_r <= count_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (cyc_we) cyc_mem[cyc_wa] <= cyc_wd;
    cyc_rd_r <= cyc_mem[cyc_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      prev_idx_r   <= '0;
      prev_v_r     <= 1'b0;
      step_total_r <= 32'd0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == LAST_IDX) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur_r <= q_item;
            if (q_item.kind == KIND_STEP) begin
              state_r <= S_SRD;
            end else begin
              state_r     <= S_SCAN;
              limit_r     <= limit_nxt;
              n_r         <= 7'd0;
              have_prev_r <= 1'b0;
              pend_v_r    <= 1'b0;
              scan_r      <= '0;
              scan_done_r <= 1'b0;
              cmp_v_r     <= 1'b0;
              found_r     <= 1'b0;
            end
          end
        end
        S_SRD: state_r <= S_SWR;
        S_SWR: begin
          step_total_r <= step_total_r + 32'd1;
          prev_v_r     <= cur_r.in_range;
          if (cur_r.in_range) prev_idx_r <= cur_idx;
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          if (cmp_v_r && cand_ok && cand_better) begin
            found_r    <= 1'b1;
            best_cnt_r <= cnt_rd_r;
            best_idx_r <= cmp_idx_r;
          end
          if (!scan_done_r) begin
            cmp_idx_r <= scan_r;
            cmp_v_r   <= 1'b1;
            if (scan_r == LAST_IDX) scan_done_r <= 1'b1;
            else scan_r <= scan_r + IW'(1);
          end else if (cmp_v_r) begin
            cmp_v_r <= 1'b0;
          end else begin
            if (found_r) begin
              if (pend_v_r) begin
                out_valid_r <= 1'b1;
                out_r       <= pend_r;
              end
              state_r <= S_CYC;
            end else begin
              out_valid_r <= 1'b1;
              if (pend_v_r) begin
                out_r <= '{inst_addr: pend_r.inst_addr, exec_count: pend_r.exec_count,
                           avg_cycles: pend_r.avg_cycles,
                           total_steps: pend_r.total_steps, last: 1'b1};
              end else begin
                out_r <= '{inst_addr: 32'd0, exec_count: 32'd0, avg_cycles: 32'd0,
                           total_steps: step_total_r, last: 1'b1};
              end
              state_r <= S_IDLE;
            end
          end
        end
        S_CYC: state_r <= S_LOAD;
        S_LOAD: begin
          rem_r   <= 32'd0;
          quo_r   <= cyc_rd_r;
          k_r     <= 5'd0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          k_r   <= k_r + 5'd1;
          if (k_r == 5'd31) begin
            pend_r.inst_addr   <= code_base + {{(30 - IW){1'b0}}, best_idx_r, 2'b00};
            pend_r.exec_count  <= best_cnt_r;
            pend_r.avg_cycles  <= quo_nxt;
            pend_r.total_steps <= step_total_r;
            pend_r.last        <= 1'b0;
            pend_v_r    <= 1'b1;
            n_r         <= n_r + 7'd1;
            have_prev_r <= 1'b1;
            rank_cnt_r  <= best_cnt_r;
            rank_idx_r  <= best_idx_r;
            if (n_r + 7'd1 == limit_r) begin
              out_valid_r <= 1'b1;
              out_r <= '{inst_addr: code_base + {{(30 - IW){1'b0}}, best_idx_r, 2'b00},
                         exec_count: best_cnt_r, avg_cycles: quo_nxt,
                         total_steps: step_total_r, last: 1'b1};
              state_r <= S_IDLE;
            end else begin
              scan_r      <= '0;
              scan_done_r <= 1'b0;
              cmp_v_r     <= 1'b0;
              found_r     <= 1'b0;
              state_r     <= S_SCAN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/pc_profile_histogram_core.sv =====
// top level of the pc profile histogram: config registers, front end and back end
//
// input items transfer on a rising edge with in_start high and busy low;
// in_data.kind selects a step event or a dump request
// a step event updates the count and cycle tables and gives no result;
// it has a read state and a write state, for the two table read-modify-writes
// a dump gives up to top_n results (at least one, at most 64), one out_valid
// strobe each, with last set on the final one; each result takes one ranking
// scan over the count table and a serial divide of the cycle total by the count
// a two-entry queue sits between front and back, so busy rises when that
// queue is full and while the tables are being cleared
// after reset every table entry is cleared in turn with busy high;
// config writes are taken at any time through cfg_we, cfg_index, cfg_wdata
// and must only happen while the block is idle
// results are strobed for one cycle; the receiver cannot stall them
module pc_profile_histogram_core import phh_pkg::*; #(
  parameter int ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] code_base_r;
  logic [6:0]  top_n_r;
  logic        clearing, q_pop, q_valid;
  qitem_t      q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_base_r <= CODE_BASE_RST;
      top_n_r     <= TOP_N_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CODE_BASE: code_base_r <= cfg_wdata;
        CFG_TOP_N:     top_n_r     <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  phh_front #(.ENTRIES(ENTRIES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_data(in_data),
    .code_base(code_base_r), .clearing(clearing), .busy(busy),
    .q_pop(q_pop), .q_valid(q_valid), .q_item(q_item)
  );

  phh_back #(.ENTRIES(ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .code_base(code_base_r), .top_n(top_n_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .clearing(clearing),
    .out_valid(out_valid), .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.exec_count == 32'd0) |-> out_data.last)
    else $error("zero-count result not marked last");
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop)
    else $error("queue popped during clearing pass");
`endif

endmodule

// ===== test/pc_profile_histogram_checker.sv =====
// checker for the pc profile histogram: predicts dump results and compares them
`timescale 1ns / 100ps
module pc_profile_histogram_checker import phh_pkg::*; #(
  parameter int ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_start,
  input  logic        busy,
  input  in_t         in_data,
  input  logic        out_valid,
  input  out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          mismatches,
  output int          pending
);

  logic [31:0] code_base;
  logic [6:0]  top_n;
  logic [31:0] hit_count [ENTRIES];
  logic [31:0] cycle_sum [ENTRIES];
  int unsigned last_index;
  bit          last_hit;
  logic [31:0] step_total;
  out_t        dump_q[$];

  function automatic void record_step(logic [31:0] pc, logic [31:0] cycles);
    logic [31:0] word;
    word = (pc - code_base) >> 2;
    step_total = step_total + 32'd1;
    if (last_hit) begin
      cycle_sum[last_index] = cycle_sum[last_index] + cycles;
    end
    if (word < ENTRIES) begin
      hit_count[word] = hit_count[word] + 32'd1;
      last_index = word;
      last_hit = 1'b1;
    end else begin
      last_hit = 1'b0;
    end
  endfunction

  function automatic void rank_entries();
    int limit;
    int n;
    int best;
    bit have_prev;
    logic [31:0] prev_cnt;
    int prev_idx;
    out_t res;
    limit = (top_n == 0) ? 1 : (top_n > MAX_REPORT) ? int'(MAX_REPORT) : int'(top_n);
    have_prev = 1'b0;
    prev_cnt = '0;
    prev_idx = 0;
    n = 0;
    while (n < limit) begin
      best = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_count[i] == 0) continue;
        // only entries ranked strictly after the previous report
        if (have_prev && !((prev_cnt > hit_count[i]) ||
                           (prev_cnt == hit_count[i] && prev_idx < i))) continue;
        if (best < 0 || hit_count[i] > hit_count[best]) best = i;
      end
      if (best < 0) break;
      res.inst_addr   = code_base + (32'(best) << 2);
      res.exec_count  = hit_count[best];
      res.avg_cycles  = cycle_sum[best] / hit_count[best];
      res.total_steps = step_total;
      res.last        = 1'b0;
      dump_q.push_back(res);
      have_prev = 1'b1;
      prev_cnt = hit_count[best];
      prev_idx = best;
      n++;
    end
    if (n == 0) begin
      res = '0;
      res.total_steps = step_total;
      res.last = 1'b1;
      dump_q.push_back(res);
    end else begin
      dump_q[dump_q.size() - 1].last = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      mismatches = 0;
      code_base = CODE_BASE_RST;
      top_n = TOP_N_RST;
      for (int i = 0; i < ENTRIES; i++) begin
        hit_count[i] = '0;
        cycle_sum[i] = '0;
      end
      last_index = 0;
      last_hit = 1'b0;
      step_total = '0;
      dump_q.delete();
    end else begin
      if (out_valid) begin
        if (dump_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", out_data);
        end else begin
          exp_r = dump_q.pop_front();
          if (out_data.inst_addr !== exp_r.inst_addr ||
              out_data.exec_count !== exp_r.exec_count ||
              out_data.avg_cycles !== exp_r.avg_cycles ||
              out_data.total_steps !== exp_r.total_steps ||
              out_data.last !== exp_r.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected addr %h count %h avg %h total %h last %b",
                       exp_r.inst_addr, exp_r.exec_count, exp_r.avg_cycles,
                       exp_r.total_steps, exp_r.last);
              $display("                 actual   addr %h count %h avg %h total %h last %b",
                       out_data.inst_addr, out_data.exec_count, out_data.avg_cycles,
                       out_data.total_steps, out_data.last);
            end
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_CODE_BASE) code_base = cfg_wdata;
        else top_n = cfg_wdata[6:0];
      end
      if (in_start && !busy) begin
        if (in_data.kind == KIND_STEP) record_step(in_data.pc, in_data.cycles);
        else rank_entries();
      end
    end
    pending <= dump_q.size();
  end

endmodule

// ===== test/testbench.sv =====
// testbench top for the pc profile histogram: stimulus, config phases and verdict
`timescale 1ns / 100ps
module testbench;
  import phh_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_start;
  logic        busy;
  in_t         in_data;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  int          mismatches;
  int          pending;
  int          result_cnt;
  int          item_cnt;
  logic [31:0] base_now;
  bit          no_gaps;

  pc_profile_histogram_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  pc_profile_histogram_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    if (!rst_n) result_cnt = 0;
    else if (out_valid) result_cnt++;
  end

  initial begin
    #150_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send(logic kind, logic [31:0] pc, logic [31:0] cycles);
    in_t it;
    if (!no_gaps && $urandom_range(0, 99) < 38) begin
      in_start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    it.kind = kind;
    it.pc = pc;
    it.cycles = cycles;
    in_start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    item_cnt++;
  endtask

  task automatic step(logic [31:0] pc, logic [31:0] cycles);
    send(KIND_STEP, pc, cycles);
  endtask

  task automatic dump();
    send(KIND_DUMP, $urandom, $urandom);
  endtask

  task automatic settle();
    in_start <= 1'b0;
    repeat (3) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_CODE_BASE) base_now = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_step();
    logic [31:0] pc;
    logic [31:0] cyc;
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) pc = base_now + 4 * $urandom_range(0, 63) + $urandom_range(0, 3);
    else if (r < 85) pc = base_now + 4 * $urandom_range(0, 4095) + $urandom_range(0, 3);
    else if (r < 92) pc = base_now + 4 * $urandom_range(4096, 32'h3FFF_FFFF);
    else pc = $urandom;
    cyc = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 200) : $urandom;
    step(pc, cyc);
  endtask

  initial begin
    int phase;
    rst_n = 1'b0;
    in_start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_CODE_BASE;
    cfg_wdata = '0;
    base_now = CODE_BASE_RST;
    no_gaps = 1'b0;
    item_cnt = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, first step, wrap of cycle totals, table edges, out of range
    dump();
    step(32'h0000_8000, 32'hFFFF_FFFF);
    step(32'h0000_8004, 32'd7);
    step(32'h0000_8004, 32'hFFFF_FFFF);
    step(32'h0000_8007, 32'hFFFF_FFFF);
    step(32'h0000_8000 + 4 * 4095 + 3, 32'd9);
    step(32'h0000_8000 + 4 * 4096, 32'd11);
    step(32'h0000_8001, 32'd13);
    step(32'h0000_7FFC, 32'd15);
    step(32'hFFFF_FFFF, 32'd0);
    step(32'h0000_0000, 32'h8000_0000);
    step(32'h0000_8000, 32'd3);
    dump();
    settle();
    while (busy) @(posedge clk);
    write_reg(CFG_TOP_N, 32'hFFFF_FF80);
    dump();
    settle();
    write_reg(CFG_TOP_N, 32'h0000_007F);
    write_reg(CFG_CODE_BASE, 32'hFFFF_FFF8);
    step(32'hFFFF_FFF8, 32'd1);
    step(32'h0000_0004, 32'd2);
    step(32'hFFFF_FFFC, 32'd100);
    dump();
    settle();
    write_reg(CFG_CODE_BASE, 32'h0000_0000);
    write_reg(CFG_TOP_N, 32'd1);
    step(32'h0000_0000, 32'd5);
    dump();
    settle();

    // fill many entries, then a full-size dump
    write_reg(CFG_CODE_BASE, CODE_BASE_RST);
    write_reg(CFG_TOP_N, 32'd64);
    for (int i = 0; i < 150; i++) random_step();
    dump();
    settle();

    phase = 0;
    while (item_cnt < 430 || result_cnt < 60) begin
      write_reg(CFG_TOP_N, $urandom_range(1, 4));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_CODE_BASE, $urandom);
      else write_reg(CFG_CODE_BASE, CODE_BASE_RST + 4 * $urandom_range(0, 32));
      no_gaps = (phase == 1);
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 99) < 3) dump();
        else random_step();
      end
      dump();
      no_gaps = 1'b0;
      settle();
      phase++;
    end

    in_start <= 1'b0;
    repeat (3) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
